// ===== src/llh_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// llh_pkg: shared types and constants for the log-linear latency histogram
// Field widths, bucket geometry and the controller/datapath interface.
// ---------------------------------------------------------------------------
package llh_pkg;

	localparam int NUM_BUCKETS = 1024;
	localparam int BKT_AW      = $clog2(NUM_BUCKETS);
	localparam int SUB_BITS    = 4;
	localparam int SUBS        = 1 << SUB_BITS;
	localparam int OCT_W       = 6;
	localparam int RANK_BITS   = 16;
	localparam int RANK_W      = RANK_BITS + 1;
	localparam int CNT_W       = 32;
	localparam int TOTAL_W     = 48;
	localparam int VAL_W       = 63;
	localparam int CUM_W       = CNT_W + BKT_AW;
	localparam int PROD_W      = TOTAL_W + RANK_W;

	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_QUERY = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [VAL_W-1:0]   VAL_MAX   = {VAL_W{1'b1}};
	localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
	localparam logic signed [63:0] S64_MAX   = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN   = {1'b1, {63{1'b0}}};

	typedef struct packed {
		logic [1:0]         action;
		logic signed [63:0] sample_value;
		logic [RANK_W-1:0]  rank_fraction;
	} req_item_t;

	typedef struct packed {
		logic [VAL_W-1:0]   percentile_value;
		logic [TOTAL_W-1:0] total_samples;
		logic [VAL_W-1:0]   value_sum;
		logic [VAL_W-1:0]   smallest_seen;
		logic [VAL_W-1:0]   largest_seen;
		logic               is_empty;
	} rsp_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept_add;
		logic accept_query;
		logic clear_stats;
		logic ctr_zero;
		logic ctr_inc;
		logic clr_write;
		logic rd_idx;
		logic add_write;
		logic walk;
		logic res_min;
		logic res_max;
		logic res_mid;
		logic out_load;
	} llh_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic empty;
		logic rank_zero;
		logic rank_full;
		logic hit;
		logic miss;
		logic ctr_last;
		logic out_free;
	} llh_sts_t;

	// position of the leading one of a non-zero value
	function automatic logic [OCT_W-1:0] lead_pos(input logic [VAL_W-1:0] v);
		logic [OCT_W-1:0] p;
		p = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (v[i]) begin
				p = OCT_W'(i);
			end
		end
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== src/llh_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// llh_ctrl: sequencer for the histogram
// Steps clear sweeps, bucket read-modify-writes and the percentile walk.
// ---------------------------------------------------------------------------
module llh_ctrl
	import llh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	input  wire logic [1:0] req_action,
	output logic           req_stall,
	input  wire llh_sts_t  sts,
	output llh_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_ADD_IDX, S_ADD_WR, S_Q_CHK, S_Q_WALK, S_Q_MID, S_Q_FIN
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign req_stall = (state_q != S_IDLE);
	assign take      = req_valid && (state_q == S_IDLE);

	// command decode and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_write = 1'b1;
				cmd.ctr_inc   = 1'b1;
				if (sts.ctr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (take) begin
					unique case (req_action)
						ACT_ADD: begin
							cmd.accept_add = 1'b1;
							state_d        = S_ADD_IDX;
						end
						ACT_QUERY: begin
							cmd.accept_query = 1'b1;
							state_d          = S_Q_CHK;
						end
						ACT_CLEAR: begin
							cmd.clear_stats = 1'b1;
							cmd.ctr_zero    = 1'b1;
							state_d         = S_CLR;
						end
						default: ;
					endcase
				end
			end
			S_ADD_IDX: begin
				cmd.rd_idx = 1'b1;
				state_d    = S_ADD_WR;
			end
			S_ADD_WR: begin
				cmd.add_write = 1'b1;
				state_d       = S_IDLE;
			end
			S_Q_CHK: begin
				if (sts.empty) begin
					state_d = S_Q_FIN;
				end else if (sts.rank_zero) begin
					cmd.res_min = 1'b1;
					state_d     = S_Q_FIN;
				end else if (sts.rank_full) begin
					cmd.res_max = 1'b1;
					state_d     = S_Q_FIN;
				end else begin
					cmd.ctr_zero = 1'b1;
					state_d      = S_Q_WALK;
				end
			end
			S_Q_WALK: begin
				cmd.walk    = 1'b1;
				cmd.ctr_inc = 1'b1;
				if (sts.hit) begin
					state_d = S_Q_MID;
				end else if (sts.miss) begin
					cmd.res_max = 1'b1;
					state_d     = S_Q_FIN;
				end
			end
			S_Q_MID: begin
				cmd.res_mid = 1'b1;
				state_d     = S_Q_FIN;
			end
			S_Q_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register, sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/llh_dpath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// llh_dpath: histogram datapath
// Bucket memory, statistics, rank threshold, cumulative walk and output item.
// ---------------------------------------------------------------------------
module llh_dpath
	import llh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire req_item_t req,
	input  wire llh_cmd_t  cmd,
	output llh_sts_t       sts,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_item_t      rsp
);

	logic [CNT_W-1:0]  mem [NUM_BUCKETS];
	logic [CNT_W-1:0]  rdata_q;
	logic [BKT_AW-1:0] raddr;
	logic              we;
	logic [BKT_AW-1:0] waddr;
	logic [CNT_W-1:0]  wdata;

	logic [TOTAL_W-1:0]  total_q;
	logic [VAL_W-1:0]    sum_q;
	logic signed [63:0]  min_q;
	logic signed [63:0]  max_q;

	logic [VAL_W-1:0]    v_q;
	logic [OCT_W-1:0]    oct_q;
	logic [BKT_AW-1:0]   idx_q;
	logic [BKT_AW-1:0]   idx_c;
	logic [RANK_W-1:0]   rank_q;
	logic [PROD_W-1:0]   prod_q;
	logic [BKT_AW-1:0]   ctr_q;
	logic                pv_s1;
	logic [BKT_AW-1:0]   pidx_s1;
	logic [CUM_W-1:0]    cum_q;
	logic [CUM_W-1:0]    cum_n;
	logic [BKT_AW-1:0]   hit_idx_q;
	logic [VAL_W-1:0]    res_q;
	logic                rsp_valid_q;
	logic                hit_c;

	logic [VAL_W-1:0]    v_in;
	logic [63:0]         sum_ext;
	logic [OCT_W-1:0]    sh;
	logic [VAL_W-1:0]    vshift;
	logic [SUB_BITS-1:0] sub_c;

	logic [OCT_W-1:0]    m_oct;
	logic [SUB_BITS-1:0] m_sub;
	logic [OCT_W-1:0]    m_sh;
	logic [63:0]         m_base;
	logic [63:0]         m_half;
	logic [63:0]         m_val;
	logic [63:0]         m_clamp;

	// clamped sample and saturating sum
	assign v_in    = req.sample_value[63] ? '0 : req.sample_value[VAL_W-1:0];
	assign sum_ext = {1'b0, sum_q} + {1'b0, v_in};

	// bucket index of the registered sample
	assign sh     = oct_q - OCT_W'(SUB_BITS);
	assign vshift = v_q >> sh;
	always_comb begin
		if (oct_q >= OCT_W'(SUB_BITS)) begin
			sub_c = vshift[SUB_BITS-1:0];
		end else begin
			sub_c = v_q[SUB_BITS-1:0];
		end
		if (v_q == '0) begin
			idx_c = '0;
		end else begin
			idx_c = {oct_q, sub_c};
		end
	end

	// memory port control
	assign raddr = cmd.rd_idx ? idx_c : ctr_q;
	assign we    = cmd.clr_write || cmd.add_write;
	assign waddr = cmd.clr_write ? ctr_q : idx_q;
	assign wdata = cmd.clr_write ? '0 :
		((rdata_q == CNT_MAX) ? rdata_q : rdata_q + CNT_W'(1));

	// bucket memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// walk compare against threshold
	assign cum_n = cum_q + CUM_W'(rdata_q);
	assign hit_c = pv_s1 && (rdata_q != '0) &&
		({{(PROD_W-CUM_W-RANK_BITS){1'b0}}, cum_n, {RANK_BITS{1'b0}}} >= prod_q);

	// bucket midpoint of the covering bucket, clamped to min and max
	assign m_oct  = hit_idx_q[BKT_AW-1:SUB_BITS];
	assign m_sub  = hit_idx_q[SUB_BITS-1:0];
	assign m_sh   = m_oct - OCT_W'(SUB_BITS);
	assign m_base = {{(64-SUB_BITS-1){1'b0}}, 1'b1, m_sub} << m_sh;
	assign m_half = (64'd1 << m_sh) >> 1;
	always_comb begin
		if (m_oct < OCT_W'(SUB_BITS)) begin
			m_val = {{(64-SUB_BITS){1'b0}}, m_sub};
		end else if (m_oct > OCT_W'(62)) begin
			m_val = max_q;
		end else begin
			m_val = m_base + m_half;
		end
		m_clamp = m_val;
		if (m_clamp < min_q) begin
			m_clamp = min_q;
		end
		if (m_clamp > max_q) begin
			m_clamp = max_q;
		end
	end

	// statistics and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			sum_q       <= '0;
			min_q       <= S64_MAX;
			max_q       <= S64_MIN;
			ctr_q       <= '0;
			pv_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_stats) begin
				total_q <= '0;
				sum_q   <= '0;
				min_q   <= S64_MAX;
				max_q   <= S64_MIN;
			end else if (cmd.accept_add) begin
				if (total_q != TOTAL_MAX) begin
					total_q <= total_q + TOTAL_W'(1);
				end
				sum_q <= sum_ext[63] ? VAL_MAX : sum_ext[VAL_W-1:0];
				if ($signed({1'b0, v_in}) < min_q) begin
					min_q <= {1'b0, v_in};
				end
				if ($signed({1'b0, v_in}) > max_q) begin
					max_q <= {1'b0, v_in};
				end
			end
			if (cmd.ctr_zero) begin
				ctr_q <= '0;
			end else if (cmd.ctr_inc) begin
				ctr_q <= ctr_q + BKT_AW'(1);
			end
			if (cmd.ctr_zero) begin
				pv_s1 <= 1'b0;
			end else if (cmd.walk) begin
				pv_s1 <= 1'b1;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept_add) begin
			v_q   <= v_in;
			oct_q <= lead_pos(v_in);
		end
		if (cmd.rd_idx) begin
			idx_q <= idx_c;
		end
		if (cmd.accept_query) begin
			rank_q <= req.rank_fraction;
			prod_q <= PROD_W'(total_q) * PROD_W'(req.rank_fraction);
		end
		if (cmd.ctr_zero) begin
			cum_q <= '0;
		end else if (cmd.walk && pv_s1) begin
			cum_q <= cum_n;
		end
		if (cmd.walk) begin
			pidx_s1 <= ctr_q;
		end
		if (cmd.walk && hit_c) begin
			hit_idx_q <= pidx_s1;
		end
		if (cmd.res_min) begin
			res_q <= min_q[VAL_W-1:0];
		end else if (cmd.res_max) begin
			res_q <= max_q[VAL_W-1:0];
		end else if (cmd.res_mid) begin
			res_q <= m_clamp[VAL_W-1:0];
		end
		if (cmd.out_load) begin
			if (total_q == '0) begin
				rsp <= '{percentile_value: '0, total_samples: '0, value_sum: '0,
					smallest_seen: '0, largest_seen: '0, is_empty: 1'b1};
			end else begin
				rsp <= '{percentile_value: res_q, total_samples: total_q,
					value_sum: sum_q, smallest_seen: min_q[VAL_W-1:0],
					largest_seen: max_q[VAL_W-1:0], is_empty: 1'b0};
			end
		end
	end

	// status back to the controller
	always_comb begin
		sts.empty     = (total_q == '0);
		sts.rank_zero = (rank_q == '0);
		sts.rank_full = rank_q[RANK_BITS];
		sts.hit       = hit_c;
		sts.miss      = pv_s1 && !hit_c && (pidx_s1 == BKT_AW'(NUM_BUCKETS - 1));
		sts.ctr_last  = (ctr_q == BKT_AW'(NUM_BUCKETS - 1));
		sts.out_free  = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

// ===== src/log_linear_latency_histogram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// log_linear_latency_histogram: log-linear histogram with percentile query
// Add: bucket index, bucket read, then saturating write back.
// Clear: one bucket per cycle through the memory port.
// Query: empty state and edge ranks are answered directly, other ranks by a bucket walk.
// One item in flight; the memory port sets the pace of walk and sweep.
// Reset runs the clearing sweep over all 1024 buckets before the first item is taken.
// ---------------------------------------------------------------------------
module log_linear_latency_histogram
	import llh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_item_t      rsp
);

	llh_cmd_t cmd;
	llh_sts_t sts;

	// sequencer
	llh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req.action),
		.req_stall  (req_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath
	llh_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tb: self-checking bench for log_linear_latency_histogram
// Drives add, query, clear and unused actions through the request channel,
// keeps its own copy of the bucket counts and statistics, and checks every
// query result field by field against the oldest expected result.
// ---------------------------------------------------------------------------
module tb
	import llh_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  ACT_UNUSED = 2'd3;
	localparam logic [63:0] POS_LIMIT  = 64'h7fff_ffff_ffff_ffff;
	localparam logic [RANK_W-1:0] RANK_ONE = RANK_W'(1) << RANK_BITS;
	localparam int IDLE_LIMIT  = 20000;
	localparam int DRAIN_WAIT  = 1100;
	localparam int LONG_HOLD   = 400;
	localparam int RANDOM_ITEMS = 550;

	typedef struct {
		req_item_t item;
		bit        typed;
		rsp_item_t want;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// histogram shadow state
	bit [CNT_W-1:0]   hist_count [NUM_BUCKETS];
	bit [TOTAL_W-1:0] n_samples;
	bit [62:0]        sum_acc;
	bit [63:0]        lo_seen;
	bit [63:0]        hi_seen;

	rsp_item_t   pending_rsp [$];
	stim_row_t   stim_table [$];
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	int          quiet_cycles = 0;

	log_linear_latency_histogram uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// empty the shadow store
	function automatic void hist_clear();
		foreach (hist_count[i]) hist_count[i] = '0;
		n_samples = '0;
		sum_acc   = '0;
		lo_seen   = POS_LIMIT;
		hi_seen   = {1'b1, 63'd0};
	endfunction

	// record one sample into the shadow store
	function automatic void hist_add(input logic signed [63:0] raw);
		bit [63:0] v;
		int        oct;
		bit [63:0] sub;
		int        idx;
		v = raw[63] ? 64'd0 : 64'(raw);
		idx = 0;
		if (n_samples != TOTAL_MAX) n_samples++;
		sum_acc = (v > 64'(VAL_MAX) - 64'(sum_acc)) ? VAL_MAX : sum_acc + v[62:0];
		if ($signed(v) < $signed(lo_seen)) lo_seen = v;
		if ($signed(v) > $signed(hi_seen)) hi_seen = v;
		if (v != 0) begin
			oct = 0;
			for (int i = 0; i < 64; i++) if (v[i]) oct = i;
			if (oct >= SUB_BITS) sub = (v >> (oct - SUB_BITS)) & (SUBS - 1);
			else sub = v & (SUBS - 1);
			idx = oct * SUBS + int'(sub);
			if (idx >= NUM_BUCKETS) idx = NUM_BUCKETS - 1;
		end
		if (hist_count[idx] != CNT_MAX) hist_count[idx]++;
	endfunction

	// centre of a bucket, falling back to the maximum where it overflows
	function automatic bit [63:0] bin_midpoint(input int i);
		int        oct;
		bit [63:0] sub;
		bit [63:0] lowv;
		bit [63:0] wid;
		oct = i / SUBS;
		sub = 64'(i % SUBS);
		if (oct < SUB_BITS) return sub;
		if (oct > 62) return hi_seen;
		lowv = 64'd1 << oct;
		wid  = 64'd1 << (oct - SUB_BITS);
		if (sub > (POS_LIMIT - lowv) / wid) return hi_seen;
		lowv += sub * wid;
		if (wid / 2 > POS_LIMIT - lowv) return hi_seen;
		return lowv + wid / 2;
	endfunction

	// value at a rank by walking cumulative counts
	function automatic bit [63:0] rank_value(input bit [RANK_W-1:0] rank);
		bit [127:0] target;
		bit [127:0] reach;
		bit [63:0]  cum;
		bit [63:0]  mid;
		if (rank == 0) return lo_seen;
		if (rank >= RANK_ONE) return hi_seen;
		target = 128'(n_samples) * 128'(rank);
		cum = 0;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			cum += hist_count[i];
			if (hist_count[i] != 0) begin
				reach = 128'(cum) << RANK_BITS;
				if (reach >= target) begin
					mid = bin_midpoint(i);
					if (mid < lo_seen) mid = lo_seen;
					if (mid > hi_seen) mid = hi_seen;
					return mid;
				end
			end
		end
		return hi_seen;
	endfunction

	function automatic rsp_item_t query_result(input bit [RANK_W-1:0] rank);
		rsp_item_t r;
		r = '0;
		if (n_samples == 0) begin
			r.is_empty = 1'b1;
			return r;
		end
		r.percentile_value = 63'(rank_value(rank) & POS_LIMIT);
		r.total_samples    = n_samples;
		r.value_sum        = sum_acc;
		r.smallest_seen    = lo_seen[62:0];
		r.largest_seen     = hi_seen[62:0];
		return r;
	endfunction

	// apply an accepted item to the shadow store, queueing any result
	function automatic void apply_item(input req_item_t it, input bit typed,
			input rsp_item_t want);
		case (it.action)
			ACT_ADD:   hist_add(it.sample_value);
			ACT_CLEAR: hist_clear();
			ACT_QUERY: pending_rsp.push_back(typed ? want : query_result(it.rank_fraction));
			default: ;
		endcase
	endfunction

	function automatic void add_row(input logic [1:0] act, input logic signed [63:0] s,
			input logic [RANK_W-1:0] r, input bit typed, input rsp_item_t want);
		stim_row_t row;
		row.item  = '{action: act, sample_value: s, rank_fraction: r};
		row.typed = typed;
		row.want  = want;
		stim_table.push_back(row);
	endfunction

	function automatic logic signed [63:0] pick_sample();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 9)) inside
			[0:1]:   return 64'($urandom_range(0, 20));
			2:       return {1'b1, w[62:0]};
			3:       return w;
			4:       return $urandom_range(0, 1) ? S64_MAX : S64_MIN;
			default: return w >> $urandom_range(1, 63);
		endcase
	endfunction

	function automatic req_item_t pick_item();
		req_item_t it;
		int        roll;
		roll = $urandom_range(0, 99);
		it.sample_value  = pick_sample();
		it.rank_fraction = $urandom_range(0, 3) == 0 ?
			RANK_W'($urandom_range(0, 2) == 0 ? 0 : $urandom) : RANK_W'($urandom_range(0, 65535));
		if (roll < 72) it.action = ACT_ADD;
		else if (roll < 93) it.action = ACT_QUERY;
		else if (roll < 96) it.action = ACT_CLEAR;
		else it.action = ACT_UNUSED;
		return it;
	endfunction

	// offer one item and hold it until accepted
	task automatic offer(input req_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	// result side: random stalls and one long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// result checking
	always @(posedge clk) begin
		rsp_item_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", rsp);
			end else begin
				e = pending_rsp.pop_front();
				if (e.percentile_value !== rsp.percentile_value ||
						e.total_samples !== rsp.total_samples ||
						e.value_sum !== rsp.value_sum ||
						e.smallest_seen !== rsp.smallest_seen ||
						e.largest_seen !== rsp.largest_seen ||
						e.is_empty !== rsp.is_empty) begin
					mismatches++;
					if (mismatches <= 10) $display("result mismatch\n  exp %p\n  got %p", e, rsp);
				end
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		rsp_item_t   empty_rsp;
		rsp_item_t   w;
		req_item_t   it;
		hist_clear();
		empty_rsp = '0;
		empty_rsp.is_empty = 1'b1;

		// directed table
		add_row(ACT_QUERY, 64'sd0, 17'd1000, 1'b1, empty_rsp);
		add_row(ACT_UNUSED, 64'sd7, 17'd0, 1'b0, '0);
		add_row(ACT_QUERY, -64'sd1, 17'h1ffff, 1'b1, empty_rsp);
		add_row(ACT_ADD, 64'sd5, 17'd0, 1'b0, '0);
		w = '{percentile_value: 63'd5, total_samples: 48'd1, value_sum: 63'd5,
			smallest_seen: 63'd5, largest_seen: 63'd5, is_empty: 1'b0};
		add_row(ACT_QUERY, 64'sd0, 17'd0, 1'b1, w);
		add_row(ACT_ADD, -64'sd1, 17'h1ffff, 1'b0, '0);
		add_row(ACT_ADD, S64_MIN, 17'd0, 1'b0, '0);
		add_row(ACT_ADD, S64_MAX, 17'd0, 1'b0, '0);
		add_row(ACT_ADD, 64'sd1, 17'd0, 1'b0, '0);
		add_row(ACT_ADD, 64'sd15, 17'd0, 1'b0, '0);
		add_row(ACT_ADD, 64'sd16, 17'd0, 1'b0, '0);
		add_row(ACT_ADD, 64'sd1000, 17'd0, 1'b0, '0);
		w = '{percentile_value: VAL_MAX, total_samples: 48'd8, value_sum: VAL_MAX,
			smallest_seen: 63'd0, largest_seen: VAL_MAX, is_empty: 1'b0};
		add_row(ACT_QUERY, 64'sd0, RANK_ONE, 1'b1, w);
		add_row(ACT_QUERY, 64'sd0, 17'd1, 1'b0, '0);
		add_row(ACT_QUERY, 64'sd0, 17'd32768, 1'b0, '0);
		add_row(ACT_QUERY, 64'sd0, 17'd65535, 1'b0, '0);
		add_row(ACT_QUERY, 64'sd0, 17'h1ffff, 1'b0, '0);
		add_row(ACT_CLEAR, 64'sd0, 17'd0, 1'b0, '0);
		add_row(ACT_QUERY, 64'sd0, 17'd32768, 1'b1, empty_rsp);
		add_row(ACT_ADD, 64'sd3, 17'd0, 1'b0, '0);
		add_row(ACT_ADD, 64'sh4000_0000_0000_0000, 17'd0, 1'b0, '0);
		add_row(ACT_ADD, 64'sh7fff_0000_0000_0000, 17'd0, 1'b0, '0);
		add_row(ACT_QUERY, 64'sd0, 17'd49152, 1'b0, '0);
		add_row(ACT_QUERY, 64'sd0, 17'd21845, 1'b0, '0);

		// reset
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_table[i]) begin
			offer(stim_table[i].item);
			apply_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
		end
		drain();

		// random part in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 52 : 0;
			recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 17 : 0;
			if (ph == 0) hold_req = 1'b1;
			for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
				it = pick_item();
				if (ph == 0 && n < 6) it.action = (n % 2) ? ACT_ADD : ACT_QUERY;
				offer(it);
				apply_item(it, 1'b0, '0);
			end
			drain();
		end

		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/llh_pkg.sv
src/llh_ctrl.sv
src/llh_dpath.sv
src/log_linear_latency_histogram.sv
bench/tb.sv
